>>> rtl/core/edge_hash_lookup_or_insert_macros.svh
// Assertion macros for the edge hash lookup/insert block.
// Every macro samples on clock and is disabled while reset is high.
`ifndef EDGE_HASH_LOOKUP_OR_INSERT_MACROS_SVH
`define EDGE_HASH_LOOKUP_OR_INSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// plain property, checked at every edge
`define EHL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// same-cycle implication
`define EHL_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define EHL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define EHL_ASSERT(label, prop, msg)
`define EHL_ASSERT_IMPLY(label, ante, cons, msg)
`define EHL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/core/ehl_pkg.sv
`timescale 1ns / 1ps
package ehl_pkg;

   // table geometry
   localparam int BUCKET_COUNT = 1024;
   localparam int ENTRY_COUNT  = 4096;
   localparam int BUCKET_AW    = $clog2(BUCKET_COUNT);
   localparam int ENTRY_AW     = $clog2(ENTRY_COUNT);
   localparam int CNT_W        = BUCKET_AW + 1;   // effective bucket count
   localparam int USED_W       = ENTRY_AW + 1;    // 0..ENTRY_COUNT
   localparam int LINK_W       = ENTRY_AW + 1;    // valid + entry number

   // field widths
   localparam int POINT_W = 24;
   localparam int MAT_W   = 8;
   localparam int NB_W    = 11;
   localparam int KEY_W   = 2 * POINT_W + MAT_W;
   localparam int ENTRY_W = KEY_W + LINK_W;

   // stream packing
   localparam int REQ_DATA_W = ((KEY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ENTRY_AW + 7) / 8) * 8;
   localparam int RSP_USER_W = 2;

   // hash arithmetic
   localparam int HASH_W    = 32;
   localparam int COEF_W    = 18;
   localparam int MAC_STEPS = 3;
   localparam int STEP_W    = $clog2(MAC_STEPS);
   localparam int DIV_CNT_W = $clog2(HASH_W);

   localparam logic [COEF_W-1:0] COEF_MAT = COEF_W'(521);
   localparam logic [COEF_W-1:0] COEF_LO  = COEF_W'(18457);
   localparam logic [COEF_W-1:0] COEF_HI  = COEF_W'(234749);

   localparam logic [STEP_W-1:0] STEP_MAT = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_LO  = STEP_W'(1);

   // multiplier constant for each accumulate step
   function automatic logic [COEF_W-1:0] hash_coef(input logic [STEP_W-1:0] step);
      logic [COEF_W-1:0] coef;
      case (step)
         STEP_MAT: coef = COEF_MAT;
         STEP_LO:  coef = COEF_LO;
         default:  coef = COEF_HI;
      endcase
      return coef;
   endfunction

   // hash unit status toward the sequencer
   typedef struct packed {
      logic                 done;
      logic [BUCKET_AW-1:0] bucket;
   } hash_status_type;

endpackage

>>> rtl/core/edge_hash_lookup_or_insert.sv
// Hash: 3 multiply-accumulate steps on one multiplier, a sign step, 32 remainder steps and a
//   fix-up step; then the bucket chain is compared entry by entry, and a miss inserts unless
//   the table is full. One edge at a time: the next input is taken once the result is
//   registered, later while an earlier result waits on rsp_tready.
// Reset: synchronous, active high; a clearing pass then walks the 1024 bucket heads,
//   one per cycle, before the first input is taken. Bucket count resets to 1024.
`timescale 1ns / 1ps
`include "edge_hash_lookup_or_insert_macros.svh"
module edge_hash_lookup_or_insert (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: point_a [23:0], point_b [47:24], material [55:48]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ehl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tdata: entry_index [11:0]; tuser: was_new [0], table_full [1]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ehl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [ehl_pkg::RSP_USER_W-1:0]   rsp_tuser,
   // bucket count register
   input  logic                             csr_wr_en,
   input  logic [ehl_pkg::NB_W-1:0]         csr_wr_data
);
   import ehl_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_HEADV = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_MISS  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [NB_W-1:0]       num_buckets_ff;
   logic [CNT_W-1:0]      n_eff;
   logic [BUCKET_AW-1:0]  clear_cnt_ff, clear_cnt_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [POINT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [MAT_W-1:0]      mat_ff, mat_in;
   logic [LINK_W-1:0]     head_ff, head_in;
   logic [ENTRY_AW-1:0]   cur_ff, cur_in;
   logic [ENTRY_AW-1:0]   res_idx_ff, res_idx_in;
   logic                  res_new_ff, res_new_in;
   logic                  res_full_ff, res_full_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_AW-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                  req_xfer;
   logic [POINT_W-1:0]    point_a, point_b;
   logic [MAT_W-1:0]      material;
   logic                  hash_start;
   hash_status_type       hash_status;

   logic                  head_wr_en;
   logic [BUCKET_AW-1:0]  head_wr_addr, head_rd_addr;
   logic [LINK_W-1:0]     head_wr_data, head_rd_data;
   logic                  entry_wr_en;
   logic [ENTRY_AW-1:0]   entry_wr_addr, entry_rd_addr;
   logic [ENTRY_W-1:0]    entry_wr_data, entry_rd_data;
   logic [KEY_W-1:0]      key;
   logic [LINK_W-1:0]     entry_link;
   logic                  table_is_full;

   assign point_a  = req_tdata[POINT_W-1:0];
   assign point_b  = req_tdata[2*POINT_W-1:POINT_W];
   assign material = req_tdata[KEY_W-1:2*POINT_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // bucket count as used: zero acts as one, clamp at the table size
   always_comb begin
      if (num_buckets_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (num_buckets_ff > NB_W'(BUCKET_COUNT)) begin
         n_eff = CNT_W'(BUCKET_COUNT);
      end else begin
         n_eff = CNT_W'(num_buckets_ff);
      end
   end

   ehl_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .lo     (lo_ff),
      .hi     (hi_ff),
      .mat    (mat_ff),
      .n_eff  (n_eff),
      .status (hash_status)
   );

   ehl_ram #(.WIDTH(LINK_W), .DEPTH(BUCKET_COUNT)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd_data)
   );

   ehl_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRY_COUNT)) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (entry_wr_addr),
      .wr_data (entry_wr_data),
      .rd_addr (entry_rd_addr),
      .rd_data (entry_rd_data)
   );

   // entry word: link on top of the key {material, hi, lo}
   assign key           = {mat_ff, hi_ff, lo_ff};
   assign entry_link    = entry_rd_data[ENTRY_W-1:KEY_W];
   assign table_is_full = (used_ff == USED_W'(ENTRY_COUNT));
   assign entry_rd_addr = cur_in;
   assign head_rd_addr  = hash_status.bucket;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clear_cnt_in  = clear_cnt_ff;
      used_in       = used_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mat_in        = mat_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      res_idx_in    = res_idx_ff;
      res_new_in    = res_new_ff;
      res_full_in   = res_full_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      hash_start    = 1'b0;
      head_wr_en    = 1'b0;
      head_wr_addr  = hash_status.bucket;
      head_wr_data  = {1'b1, used_ff[ENTRY_AW-1:0]};
      entry_wr_en   = 1'b0;
      entry_wr_addr = used_ff[ENTRY_AW-1:0];
      entry_wr_data = {head_ff, key};
      case (state_ff)
         S_CLEAR: begin
            head_wr_en   = 1'b1;
            head_wr_addr = clear_cnt_ff;
            head_wr_data = '0;
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               lo_in      = (point_b < point_a) ? point_b : point_a;
               hi_in      = (point_b < point_a) ? point_a : point_b;
               mat_in     = material;
               hash_start = 1'b1;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            // head read is issued with the finished bucket
            if (hash_status.done) begin
               state_in = S_HEADV;
            end
         end
         S_HEADV: begin
            head_in = head_rd_data;
            if (head_rd_data[LINK_W-1]) begin
               cur_in   = head_rd_data[ENTRY_AW-1:0];
               state_in = S_CMP;
            end else begin
               state_in = S_MISS;
            end
         end
         S_CMP: begin
            // one chain entry per cycle
            if (entry_rd_data[KEY_W-1:0] == key) begin
               res_idx_in  = cur_ff;
               res_new_in  = 1'b0;
               res_full_in = 1'b0;
               state_in    = S_OUT;
            end else if (entry_link[LINK_W-1]) begin
               cur_in = entry_link[ENTRY_AW-1:0];
            end else begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            if (table_is_full) begin
               res_idx_in  = '0;
               res_new_in  = 1'b0;
               res_full_in = 1'b1;
            end else begin
               // new entry goes to the chain head
               entry_wr_en = 1'b1;
               head_wr_en  = 1'b1;
               used_in     = used_ff + 1'b1;
               res_idx_in  = used_ff[ENTRY_AW-1:0];
               res_new_in  = 1'b1;
               res_full_in = 1'b0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = res_idx_ff;
               rsp_user_in  = {res_full_ff, res_new_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clear_cnt_ff   <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         num_buckets_ff <= NB_W'(BUCKET_COUNT);
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            num_buckets_ff <= csr_wr_data;
         end
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mat_ff      <= mat_in;
      head_ff     <= head_in;
      cur_ff      <= cur_in;
      res_idx_ff  <= res_idx_in;
      res_new_ff  <= res_new_in;
      res_full_ff <= res_full_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_idx_ff);
   assign rsp_tuser  = rsp_user_ff;

   `EHL_ASSERT(a_used_bound, used_ff <= USED_W'(ENTRY_COUNT), "entry count overrun")
   `EHL_ASSERT_IMPLY(a_full_result, rsp_valid_ff && rsp_user_ff[1],
                     (rsp_idx_ff == '0) && !rsp_user_ff[0], "full result carries an entry")
   `EHL_ASSERT_NEXT(a_one_item, req_xfer, !req_tready, "second item taken while busy")
   `EHL_ASSERT_NEXT(a_insert_count, (state_ff == S_MISS) && !table_is_full,
                    used_ff == $past(used_ff) + 1'b1, "insert did not advance entry count")

endmodule

>>> rtl/core/ehl_ram.sv
`timescale 1ns / 1ps
module ehl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ehl_hash.sv
`timescale 1ns / 1ps
`include "edge_hash_lookup_or_insert_macros.svh"
module ehl_hash (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ehl_pkg::POINT_W-1:0]   lo,
   input  logic [ehl_pkg::POINT_W-1:0]   hi,
   input  logic [ehl_pkg::MAT_W-1:0]     mat,
   input  logic [ehl_pkg::CNT_W-1:0]     n_eff,
   output ehl_pkg::hash_status_type      status
);
   import ehl_pkg::*;

   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_MAC  = 3'd1;
   localparam logic [2:0] H_ABS  = 3'd2;
   localparam logic [2:0] H_DIV  = 3'd3;
   localparam logic [2:0] H_FIX  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [HASH_W-1:0]     acc_ff, acc_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [HASH_W-1:0]     div_ff, div_in;
   logic [BUCKET_AW-1:0]  rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  done_ff, done_in;
   logic [BUCKET_AW-1:0]  bucket_ff, bucket_in;

   logic [POINT_W-1:0]        mul_a;
   logic [COEF_W-1:0]         mul_b;
   logic [POINT_W+COEF_W-1:0] prod;
   logic [CNT_W-1:0]          trial;
   logic [CNT_W-1:0]          trial_sub;

   // shared multiplier: one term of the key sum per step
   always_comb begin
      case (step_ff)
         STEP_MAT: mul_a = POINT_W'(mat);
         STEP_LO:  mul_a = lo;
         default:  mul_a = hi;
      endcase
      mul_b = hash_coef(step_ff);
      prod  = mul_a * mul_b;
   end

   // one restoring remainder step per cycle
   assign trial     = {rem_ff, div_ff[HASH_W-1]};
   assign trial_sub = trial - n_eff;

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      bucket_in = bucket_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               acc_in   = '0;
               step_in  = '0;
               state_in = H_MAC;
            end
         end
         H_MAC: begin
            acc_in  = acc_ff + prod[HASH_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(MAC_STEPS - 1)) begin
               state_in = H_ABS;
            end
         end
         H_ABS: begin
            // divide the magnitude, fix the sign afterward
            neg_in   = acc_ff[HASH_W-1];
            div_in   = acc_ff[HASH_W-1] ? (~acc_ff + 1'b1) : acc_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = H_DIV;
         end
         H_DIV: begin
            rem_in = (trial >= n_eff) ? trial_sub[BUCKET_AW-1:0] : trial[BUCKET_AW-1:0];
            div_in = div_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = H_FIX;
            end
         end
         H_FIX: begin
            // negative sum: bucket count minus the remainder
            if (neg_ff && (rem_ff != '0)) begin
               bucket_in = BUCKET_AW'(n_eff - CNT_W'(rem_ff));
            end else begin
               bucket_in = rem_ff;
            end
            done_in  = 1'b1;
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      bucket_ff <= bucket_in;
   end

   assign status.done   = done_ff;
   assign status.bucket = bucket_ff;

   `EHL_ASSERT_NEXT(a_done_pulse, done_ff, !done_ff, "hash done held longer than one cycle")
   `EHL_ASSERT_IMPLY(a_bucket_range, done_ff, CNT_W'(bucket_ff) < n_eff, "bucket beyond count")
   `EHL_ASSERT_IMPLY(a_start_idle, start, state_ff == H_IDLE, "hash started while busy")

endmodule
